// ----- src/table_interpolator_defines.svh -----
// assertion macros for the table interpolator
// used by the top level only; set NO_ASSERTIONS to leave them out
`ifndef TABLE_INTERPOLATOR_DEFINES_SVH
`define TABLE_INTERPOLATOR_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define TI_ASSERT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define TI_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define TI_ASSERT(lbl, ante, cons)
`define TI_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- src/ti_pkg.sv -----
// shared types, codes and saturation helpers for the table interpolator
// no dependencies
package ti_pkg;

    localparam int MAX_POINTS = 8;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int PIDX_W     = 3;
    localparam int PIU_W      = 4;
    localparam int PIU_RESET  = 4;
    localparam int ADDR_W     = 3;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_DIVZ  = 2'd2;

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
    localparam logic signed [34:0] W_MAX   = 35'sh0_7FFF_FFFF;
    localparam logic signed [34:0] W_MIN   = 35'sh7_8000_0000;

    typedef struct packed {
        logic             in_take;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             load_a;
        logic             load_i;
        logic             lin_div_start;
        logic             lin_f;
        logic             lin_mul;
        logic             lin_fin;
        logic             lg_div_start;
        logic             lg_fac;
        logic             lg_mul;
        logic             lg_rnd;
        logic             acc_add;
        logic             out_load;
        logic [1:0]       out_status;
    } t_cmd;

    typedef struct packed {
        logic x_lt_q;
        logic x_gt_q;
        logic x_eq_a;
        logic div_done;
        logic out_free;
    } t_stat;

    function automatic logic signed [31:0] sat_mag(input logic [47:0] m, input logic neg);
        logic signed [31:0] res;
        if (neg) begin
            res = (m >= 48'h0000_8000_0000) ? S32_MIN : -$signed(m[31:0]);
        end else begin
            res = (m >= 48'h0000_7FFF_FFFF) ? S32_MAX : $signed(m[31:0]);
        end
        return res;
    endfunction

    function automatic logic signed [31:0] sat35(input logic signed [34:0] v);
        logic signed [31:0] res;
        if (v > W_MAX) begin
            res = S32_MAX;
        end else if (v < W_MIN) begin
            res = S32_MIN;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    function automatic logic [CNT_W-1:0] clamp_n(input logic [PIU_W-1:0] p);
        logic [CNT_W-1:0] res;
        if (int'(p) < 2) begin
            res = CNT_W'(2);
        end else if (int'(p) > MAX_POINTS) begin
            res = CNT_W'(MAX_POINTS);
        end else begin
            res = CNT_W'(p);
        end
        return res;
    endfunction

endpackage

// ----- src/ti_divider.sv -----
// serial restoring divider, one quotient bit per cycle, 32-bit quotient
// flags a quotient of 2^32 or more at start; uses ti_pkg
module ti_divider (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_num,
    input  logic [32:0] i_den,
    output logic        o_done,
    output logic        o_ovf,
    output logic [31:0] o_quot
);
    import ti_pkg::*;

    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic        r_ovf, n_ovf;
    logic [4:0]  r_cnt, n_cnt;
    logic [32:0] r_rem, n_rem;
    logic [31:0] r_low, n_low;
    logic [33:0] trial;
    logic        ge;

    always_comb begin
        trial  = {r_rem, r_low[31]};
        ge     = trial >= {1'b0, i_den};
        n_busy = r_busy;
        n_done = 1'b0;
        n_ovf  = r_ovf;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_low  = r_low;
        if (i_start) begin
            n_rem = {1'b0, i_num[63:32]};
            n_low = i_num[31:0];
            n_cnt = 5'd31;
            if ({1'b0, i_num[63:32]} >= i_den) begin
                n_ovf  = 1'b1;
                n_done = 1'b1;
                n_busy = 1'b0;
            end else begin
                n_ovf  = 1'b0;
                n_busy = 1'b1;
            end
        end else if (r_busy) begin
            n_rem = ge ? 33'(trial - {1'b0, i_den}) : trial[32:0];
            n_low = {r_low[30:0], ge};
            n_cnt = r_cnt - 5'd1;
            if (r_cnt == 5'd0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_ovf <= n_ovf;
        r_cnt <= n_cnt;
        r_rem <= n_rem;
        r_low <= n_low;
    end

    assign o_done = r_done;
    assign o_ovf  = r_ovf;
    assign o_quot = r_low;

endmodule

// ----- src/ti_datapath.sv -----
// point table, arithmetic registers and output register of the interpolator
// uses ti_pkg and ti_divider
module ti_datapath (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  ti_pkg::t_cmd              i_cmd,
    output ti_pkg::t_stat             o_stat,
    input  logic                      i_operation,
    input  logic [2:0]                i_point_index,
    input  logic signed [31:0]        i_point_abscissa,
    input  logic signed [31:0]        i_point_ordinate,
    input  logic signed [31:0]        i_query_abscissa,
    input  logic                      i_out_stall,
    output logic                      o_out_valid,
    output logic signed [31:0]        o_linear_value,
    output logic signed [31:0]        o_lagrange_value,
    output logic [1:0]                o_status
);
    import ti_pkg::*;

    logic signed [31:0] r_mem_x [MAX_POINTS];
    logic signed [31:0] r_mem_y [MAX_POINTS];
    logic signed [31:0] r_rd_x, r_rd_y;
    logic signed [31:0] r_q, r_xa, r_ya;
    logic signed [32:0] r_dy;
    logic [31:0]        r_f;
    logic [63:0]        r_prod;
    logic               r_pneg, r_fneg;
    logic signed [31:0] r_lin, r_term, r_fac;
    logic signed [34:0] r_acc;
    logic               r_oval;
    logic signed [31:0] r_olin, r_olag;
    logic [1:0]         r_ost;

    logic signed [32:0] lin_d, lin_w, lg_num, lg_den;
    logic [32:0]        mag_num, mag_den, mag_dy;
    logic [63:0]        div_num;
    logic [32:0]        div_den;
    logic               div_done, div_ovf;
    logic [31:0]        div_quot;
    logic [31:0]        mag_t, mag_f;
    logic [64:0]        lin_p;
    logic [63:0]        lg_p, lin_rs, lg_rs;
    logic signed [33:0] lin_sum;
    logic signed [31:0] fac_val;

    always_comb begin
        lin_d   = 33'(r_q) - 33'(r_xa);
        lin_w   = 33'(r_rd_x) - 33'(r_xa);
        lg_num  = 33'(r_q) - 33'(r_rd_x);
        lg_den  = 33'(r_xa) - 33'(r_rd_x);
        mag_num = lg_num[32] ? 33'(-lg_num) : lg_num;
        mag_den = lg_den[32] ? 33'(-lg_den) : lg_den;
        mag_dy  = r_dy[32] ? 33'(-r_dy) : r_dy;
        if (i_cmd.lin_div_start) begin
            div_num = {lin_d, 31'd0};
            div_den = lin_w;
        end else begin
            div_num = {15'd0, mag_num, 16'd0};
            div_den = mag_den;
        end
        mag_t   = r_term[31] ? 32'(-r_term) : r_term;
        mag_f   = r_fac[31] ? 32'(-r_fac) : r_fac;
        lin_p   = mag_dy * r_f;
        lg_p    = mag_t * mag_f;
        lin_rs  = r_prod + 64'h0000_0000_4000_0000;
        lg_rs   = r_prod + 64'h0000_0000_0000_8000;
        lin_sum = r_dy[32] ? 34'(r_ya) - 34'(lin_rs[63:31])
                           : 34'(r_ya) + 34'(lin_rs[63:31]);
        fac_val = div_ovf ? (r_fneg ? S32_MIN : S32_MAX) : sat_mag({16'd0, div_quot}, r_fneg);
    end

    ti_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.lin_div_start | i_cmd.lg_div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_ovf   (div_ovf),
        .o_quot  (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.in_take && i_operation == OP_WRITE
                && int'(i_point_index) < MAX_POINTS) begin
            r_mem_x[IDX_W'(i_point_index)] <= i_point_abscissa;
            r_mem_y[IDX_W'(i_point_index)] <= i_point_ordinate;
        end
        if (i_cmd.rd_en) begin
            r_rd_x <= r_mem_x[i_cmd.rd_addr];
            r_rd_y <= r_mem_y[i_cmd.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.in_take && i_operation == OP_QUERY) begin
            r_q   <= i_query_abscissa;
            r_acc <= '0;
        end else if (i_cmd.acc_add) begin
            r_acc <= r_acc + 35'(r_term);
        end
        if (i_cmd.load_a) begin
            r_xa <= r_rd_x;
            r_ya <= r_rd_y;
        end else if (i_cmd.load_i) begin
            r_xa <= r_rd_x;
        end
        if (i_cmd.lin_div_start) begin
            r_dy <= 33'(r_rd_y) - 33'(r_ya);
        end
        if (i_cmd.lg_div_start) begin
            r_fneg <= lg_num[32] ^ lg_den[32];
        end
        if (i_cmd.lin_f) begin
            r_f <= div_quot;
        end
        if (i_cmd.lg_fac) begin
            r_fac <= fac_val;
        end
        if (i_cmd.lin_mul) begin
            r_prod <= lin_p[63:0];
        end else if (i_cmd.lg_mul) begin
            r_prod <= lg_p;
            r_pneg <= r_term[31] ^ r_fac[31];
        end
        if (i_cmd.lin_fin) begin
            r_lin <= sat35(35'(lin_sum));
        end
        if (i_cmd.load_i) begin
            r_term <= r_rd_y;
        end else if (i_cmd.lg_rnd) begin
            r_term <= sat_mag(lg_rs[63:16], r_pneg);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oval <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_oval <= 1'b1;
        end else if (!i_out_stall) begin
            r_oval <= 1'b0;
        end
        if (i_cmd.out_load) begin
            r_ost <= i_cmd.out_status;
            if (i_cmd.out_status == ST_OK) begin
                r_olin <= r_lin;
                r_olag <= sat35(r_acc);
            end else begin
                r_olin <= '0;
                r_olag <= '0;
            end
        end
    end

    always_comb begin
        o_stat.x_lt_q   = r_rd_x < r_q;
        o_stat.x_gt_q   = r_rd_x > r_q;
        o_stat.x_eq_a   = r_rd_x == r_xa;
        o_stat.div_done = div_done;
        o_stat.out_free = !r_oval || !i_out_stall;
    end

    assign o_out_valid      = r_oval;
    assign o_linear_value   = r_olin;
    assign o_lagrange_value = r_olag;
    assign o_status         = r_ost;

endmodule

// ----- src/ti_ctrl.sv -----
// sequencer for table writes, segment search, linear and lagrange passes
// uses ti_pkg
module ti_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic                      i_operation,
    input  logic [ti_pkg::PIU_W-1:0]  i_points,
    input  ti_pkg::t_stat             i_stat,
    output ti_pkg::t_cmd              o_cmd,
    output logic                      o_idle
);
    import ti_pkg::*;

    typedef enum logic [17:0] {
        S_IDLE     = 18'h00001,
        S_SCAN_RD  = 18'h00002,
        S_SCAN_CHK = 18'h00004,
        S_LIN_RDA  = 18'h00008,
        S_LIN_LDA  = 18'h00010,
        S_LIN_LDB  = 18'h00020,
        S_LIN_DIV  = 18'h00040,
        S_LIN_MUL  = 18'h00080,
        S_LIN_FIN  = 18'h00100,
        S_LG_RDI   = 18'h00200,
        S_LG_LDI   = 18'h00400,
        S_LG_RDJ   = 18'h00800,
        S_LG_LDJ   = 18'h01000,
        S_LG_DIV   = 18'h02000,
        S_LG_MUL   = 18'h04000,
        S_LG_RND   = 18'h08000,
        S_LG_ACC   = 18'h10000,
        S_OUT      = 18'h20000
    } t_state;

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_i, n_i, r_j, n_j, r_k, n_k, r_last, n_last;
    logic             r_found, n_found, r_range, n_range, r_dup, n_dup;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        n_i     = r_i;
        n_j     = r_j;
        n_k     = r_k;
        n_last  = r_last;
        n_found = r_found;
        n_range = r_range;
        n_dup   = r_dup;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.in_take = 1'b1;
                    if (i_operation == OP_QUERY) begin
                        n_last  = IDX_W'(clamp_n(i_points) - CNT_W'(1));
                        n_found = 1'b0;
                        n_range = 1'b0;
                        n_dup   = 1'b0;
                        n_j     = '0;
                        n_state = S_SCAN_RD;
                    end
                end
            end
            S_SCAN_RD: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_addr = r_j;
                n_state       = S_SCAN_CHK;
            end
            S_SCAN_CHK: begin
                if (r_j == '0 && i_stat.x_gt_q) begin
                    n_range = 1'b1;
                end
                if (r_j == r_last && i_stat.x_lt_q) begin
                    n_range = 1'b1;
                end
                if (r_j != '0 && !r_found && (!i_stat.x_lt_q || r_j == r_last)) begin
                    n_found = 1'b1;
                    n_k     = r_j;
                end
                if (r_j == r_last) begin
                    n_state = n_range ? S_OUT : S_LIN_RDA;
                end else begin
                    n_j     = r_j + 1'b1;
                    n_state = S_SCAN_RD;
                end
            end
            S_LIN_RDA: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_addr = r_k - 1'b1;
                n_state       = S_LIN_LDA;
            end
            S_LIN_LDA: begin
                o_cmd.load_a  = 1'b1;
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_addr = r_k;
                n_state       = S_LIN_LDB;
            end
            S_LIN_LDB: begin
                o_cmd.lin_div_start = 1'b1;
                n_state             = S_LIN_DIV;
            end
            S_LIN_DIV: begin
                if (i_stat.div_done) begin
                    o_cmd.lin_f = 1'b1;
                    n_state     = S_LIN_MUL;
                end
            end
            S_LIN_MUL: begin
                o_cmd.lin_mul = 1'b1;
                n_state       = S_LIN_FIN;
            end
            S_LIN_FIN: begin
                o_cmd.lin_fin = 1'b1;
                n_i           = '0;
                n_state       = S_LG_RDI;
            end
            S_LG_RDI: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_addr = r_i;
                n_state       = S_LG_LDI;
            end
            S_LG_LDI: begin
                o_cmd.load_i = 1'b1;
                n_j          = '0;
                n_state      = S_LG_RDJ;
            end
            S_LG_RDJ: begin
                if (r_j == r_i) begin
                    if (r_j == r_last) begin
                        n_state = S_LG_ACC;
                    end else begin
                        n_j = r_j + 1'b1;
                    end
                end else begin
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.rd_addr = r_j;
                    n_state       = S_LG_LDJ;
                end
            end
            S_LG_LDJ: begin
                if (i_stat.x_eq_a) begin
                    n_dup = 1'b1;
                end
                o_cmd.lg_div_start = 1'b1;
                n_state            = S_LG_DIV;
            end
            S_LG_DIV: begin
                if (i_stat.div_done) begin
                    o_cmd.lg_fac = 1'b1;
                    n_state      = S_LG_MUL;
                end
            end
            S_LG_MUL: begin
                o_cmd.lg_mul = 1'b1;
                n_state      = S_LG_RND;
            end
            S_LG_RND: begin
                o_cmd.lg_rnd = 1'b1;
                if (r_j == r_last) begin
                    n_state = S_LG_ACC;
                end else begin
                    n_j     = r_j + 1'b1;
                    n_state = S_LG_RDJ;
                end
            end
            S_LG_ACC: begin
                o_cmd.acc_add = 1'b1;
                if (r_i == r_last) begin
                    n_state = S_OUT;
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = S_LG_RDI;
                end
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    if (r_range) begin
                        o_cmd.out_status = ST_RANGE;
                    end else if (r_dup) begin
                        o_cmd.out_status = ST_DIVZ;
                    end else begin
                        o_cmd.out_status = ST_OK;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_found <= 1'b0;
            r_range <= 1'b0;
            r_dup   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_found <= n_found;
            r_range <= n_range;
            r_dup   <= n_dup;
        end
        r_i    <= n_i;
        r_j    <= n_j;
        r_k    <= n_k;
        r_last <= n_last;
    end

    assign o_idle = r_state == S_IDLE;

endmodule

// ----- src/table_interpolator.sv -----
// table interpolator: 8-point table of Q16.16 samples, linear and lagrange queries
// top level; uses ti_pkg, ti_ctrl, ti_datapath and the assertion macros
//
// input channel (i_in_valid / o_in_stall) carries write or query items.
// a write item stores one point and gives no result.
// a query item gives one transfer on the output channel (o_out_valid /
// i_out_stall) with the linear value, the lagrange value and a status.
// a query scans the n points in use, then runs the linear pass and the
// lagrange pass; a query out of range skips both passes. the serial
// divider, run once for the linear value and once per lagrange factor,
// sets most of the query time. one query is in flight at a time.
// the output register holds a finished result while the next item is taken.
// if the receiver stalls, a second result waits in the sequencer until
// the output register frees up, and no further item is taken meanwhile.
// reset (synchronous, active low) empties the output and sets points_in_use
// to 4; table entries are undefined until written.
// points_in_use is written over the apb port at byte address 0 (any address with paddr[2] low).
`include "table_interpolator_defines.svh"
module table_interpolator (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_operation,
    input  logic [2:0]                  i_point_index,
    input  logic signed [31:0]          i_point_abscissa,
    input  logic signed [31:0]          i_point_ordinate,
    input  logic signed [31:0]          i_query_abscissa,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic signed [31:0]          o_linear_value,
    output logic signed [31:0]          o_lagrange_value,
    output logic [1:0]                  o_status,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ti_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import ti_pkg::*;

    logic [PIU_W-1:0] r_piu;
    t_cmd             cmd;
    t_stat            stat;
    logic             idle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_piu <= PIU_W'(PIU_RESET);
        end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
            r_piu <= pwdata[PIU_W-1:0];
        end
    end

    assign pready     = 1'b1;
    assign prdata     = (paddr[2] == 1'b0) ? 32'(r_piu) : 32'd0;
    assign o_in_stall = !idle;

    ti_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_operation (i_operation),
        .i_points    (r_piu),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_idle      (idle)
    );

    ti_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_operation      (i_operation),
        .i_point_index    (i_point_index),
        .i_point_abscissa (i_point_abscissa),
        .i_point_ordinate (i_point_ordinate),
        .i_query_abscissa (i_query_abscissa),
        .i_out_stall      (i_out_stall),
        .o_out_valid      (o_out_valid),
        .o_linear_value   (o_linear_value),
        .o_lagrange_value (o_lagrange_value),
        .o_status         (o_status)
    );

    `TI_ASSERT(a_err_zero, o_out_valid && o_status != ST_OK, o_linear_value == 0 && o_lagrange_value == 0)
    `TI_ASSERT(a_load_free, cmd.out_load, !o_out_valid || !i_out_stall)
    `TI_ASSERT_NEXT(a_load_valid, cmd.out_load, o_out_valid)

endmodule

// ----- test/tb_table_interpolator.sv -----
// self-checking testbench for table_interpolator: table writes, linear and lagrange queries
// keeps its own Q16.16 model of the table and the arithmetic in a small checker class
// depends on ti_pkg and the table_interpolator top level
module tb_table_interpolator;
    import ti_pkg::*;

    localparam logic [ADDR_W-1:0] PIU_ADDR = '0;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int DRAIN_CYCLES = 2500;

    typedef struct {
        logic signed [31:0] lin;
        logic signed [31:0] lag;
        logic [1:0]         status;
    } t_interp_result;

    class interp_checker;
        logic signed [31:0] abscissa [MAX_POINTS];
        logic signed [31:0] ordinate [MAX_POINTS];
        logic [PIU_W-1:0]   piu;
        t_interp_result     pending_results [$];
        int                 errors;

        function new();
            piu = PIU_W'(PIU_RESET);
            errors = 0;
            foreach (abscissa[i]) begin
                abscissa[i] = 0;
                ordinate[i] = 0;
            end
        endfunction

        function bit [63:0] mag(longint v);
            return v < 0 ? 64'(-v) : 64'(v);
        endfunction

        function longint sat_32(longint v);
            if (v > 64'sd2147483647) return 64'sd2147483647;
            if (v < -64'sd2147483648) return -64'sd2147483648;
            return v;
        endfunction

        function longint sat_mag(bit [63:0] m, bit neg);
            if (neg) return m >= 64'h8000_0000 ? -64'sd2147483648 : -longint'(m);
            return m >= 64'h7FFF_FFFF ? 64'sd2147483647 : longint'(m);
        endfunction

        function longint mul_q16(longint a, longint b);
            bit [63:0] p;
            p = mag(a) * mag(b);
            return sat_mag((p + 64'h8000) >> 16, (a < 0) != (b < 0));
        endfunction

        function longint div_q16(longint num, longint den);
            bit [63:0] quo;
            quo = (mag(num) << 16) / mag(den);
            return sat_mag(quo, (num < 0) != (den < 0));
        endfunction

        function void take_item(logic op, logic [2:0] idx, logic signed [31:0] px,
                                logic signed [31:0] py, logic signed [31:0] qx);
            longint xs [MAX_POINTS];
            longint ys [MAX_POINTS];
            longint q, lin, lag, dy, term;
            bit [63:0] d, w, f, p, r;
            t_interp_result res;
            int n, k;
            if (op == OP_WRITE) begin
                abscissa[idx] = px;
                ordinate[idx] = py;
                return;
            end
            n = int'(piu);
            if (n < 2) n = 2;
            if (n > MAX_POINTS) n = MAX_POINTS;
            for (int i = 0; i < n; i++) begin
                xs[i] = abscissa[i];
                ys[i] = ordinate[i];
            end
            q = qx;
            res.status = ST_OK;
            lin = 0;
            lag = 0;
            if (q < xs[0] || q > xs[n-1]) begin
                res.status = ST_RANGE;
            end else begin
                for (int i = 0; i < n; i++)
                    for (int j = i + 1; j < n; j++)
                        if (xs[i] == xs[j]) res.status = ST_DIVZ;
            end
            if (res.status == ST_OK) begin
                k = n - 1;
                for (int i = 1; i < n; i++) begin
                    if (xs[i] >= q) begin
                        k = i;
                        break;
                    end
                end
                d = q - xs[k-1];
                w = xs[k] - xs[k-1];
                f = (d << 31) / w;
                dy = ys[k] - ys[k-1];
                p = mag(dy) * f;
                r = (p + 64'h4000_0000) >> 31;
                lin = dy < 0 ? ys[k-1] - longint'(r) : ys[k-1] + longint'(r);
                lin = sat_32(lin);
                for (int i = 0; i < n; i++) begin
                    term = ys[i];
                    for (int j = 0; j < n; j++)
                        if (i != j) term = mul_q16(term, div_q16(q - xs[j], xs[i] - xs[j]));
                    lag += term;
                end
                lag = sat_32(lag);
            end
            res.lin = lin[31:0];
            res.lag = lag[31:0];
            pending_results.push_back(res);
        endfunction

        function void check_result(logic signed [31:0] lin, logic signed [31:0] lag,
                                   logic [1:0] status);
            t_interp_result e;
            if (pending_results.size() == 0) begin
                $display("%0t unexpected result lin %h lag %h status %0d",
                         $time, lin, lag, status);
                errors++;
                return;
            end
            e = pending_results.pop_front();
            if (lin !== e.lin) begin
                $display("%0t linear_value expected %h actual %h", $time, e.lin, lin);
                errors++;
            end
            if (lag !== e.lag) begin
                $display("%0t lagrange_value expected %h actual %h", $time, e.lag, lag);
                errors++;
            end
            if (status !== e.status) begin
                $display("%0t status expected %0d actual %0d", $time, e.status, status);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic               i_operation;
    logic [2:0]         i_point_index;
    logic signed [31:0] i_point_abscissa;
    logic signed [31:0] i_point_ordinate;
    logic signed [31:0] i_query_abscissa;
    logic               o_out_valid;
    logic               i_out_stall;
    logic signed [31:0] o_linear_value;
    logic signed [31:0] o_lagrange_value;
    logic [1:0]         o_status;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [ADDR_W-1:0]  paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    interp_checker sb = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_left = 0;
    int cycles = 0;

    table_interpolator u_top (.*);

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // receiver side: random stall, plus a long hold-off on request
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall = 1'b1;
            end else begin
                i_out_stall = ($urandom_range(0, 99) < recv_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result(o_linear_value, o_lagrange_value, o_status);
    end

    task automatic send_item(logic op, logic [2:0] idx, logic signed [31:0] px,
                             logic signed [31:0] py, logic signed [31:0] qx);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_operation = op;
        i_point_index = idx;
        i_point_abscissa = px;
        i_point_ordinate = py;
        i_query_abscissa = qx;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.take_item(op, idx, px, py, qx);
        @(negedge i_clk);
    endtask

    task automatic write_point(logic [2:0] idx, logic signed [31:0] px, logic signed [31:0] py);
        send_item(OP_WRITE, idx, px, py, $urandom);
    endtask

    task automatic query(logic signed [31:0] qx);
        send_item(OP_QUERY, $urandom, $urandom, $urandom, qx);
    endtask

    task automatic wait_idle();
        i_in_valid = 1'b0;
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_piu(logic [PIU_W-1:0] value);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = PIU_ADDR;
        pwdata = 32'(value);
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        sb.piu = value;
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    // eight ascending points, sometimes with a repeated abscissa
    task automatic send_sorted_table();
        longint step [MAX_POINTS];
        longint span, x;
        int sh;
        sh = $urandom_range(0, 27);
        span = 0;
        for (int i = 1; i < MAX_POINTS; i++) begin
            step[i] = ($urandom_range(0, 99) < 6) ? 0 : 1 + ($urandom % (1 << sh));
            span += step[i];
        end
        x = -64'sd2147483648 + longint'({$urandom, $urandom} % (64'd4294967296 - span));
        for (int i = 0; i < MAX_POINTS; i++) begin
            if (i > 0) x += step[i];
            write_point(3'(i), x[31:0],
                        ($urandom_range(0, 1) != 0) ? $urandom : 32'($signed($urandom % 2000000)
                        - 1000000));
        end
    endtask

    task automatic send_random_query();
        longint lo, hi;
        int n, r;
        n = int'(sb.piu);
        if (n < 2) n = 2;
        if (n > MAX_POINTS) n = MAX_POINTS;
        lo = sb.abscissa[0];
        hi = sb.abscissa[n-1];
        r = $urandom_range(0, 99);
        if (r < 12)
            query(sb.abscissa[$urandom_range(0, n - 1)]);
        else if (r < 80 && hi >= lo)
            query(32'(lo + longint'({$urandom, $urandom} % (64'(hi - lo) + 1))));
        else
            query($urandom);
    endtask

    task automatic run_phase(logic [PIU_W-1:0] piu, int idle, int stall, int count, int hold);
        int sent;
        int r;
        wait_idle();
        write_piu(piu);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        hold_left = hold;
        sent = 0;
        send_sorted_table();
        while (sent < count) begin
            r = $urandom_range(0, 99);
            if (r < 12) begin
                send_sorted_table();
                sent += MAX_POINTS;
            end else if (r < 20) begin
                write_point($urandom, $urandom, $urandom);
                sent++;
            end else begin
                send_random_query();
                sent++;
            end
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_operation = OP_WRITE;
        i_point_index = '0;
        i_point_abscissa = '0;
        i_point_ordinate = '0;
        i_query_abscissa = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // extremes with the reset value of points_in_use
        write_point(0, S32_MIN, S32_MAX);
        write_point(1, -32'sd1, S32_MIN);
        write_point(2, 32'sd0, 32'sd0);
        write_point(3, S32_MAX, S32_MAX);
        for (int i = 4; i < MAX_POINTS; i++)
            write_point(3'(i), S32_MAX, 32'(i) <<< 16);
        query(S32_MIN);
        query(S32_MAX);
        query(32'sd0);
        query(-32'sd1);
        query(32'sd12345);
        // below the first point
        write_point(0, -32'sd100 <<< 16, 32'sd7 <<< 16);
        query(S32_MIN);
        // repeated abscissa
        write_point(2, -32'sd1, 32'sd3 <<< 16);
        query(32'sd0);
        // out of range wins over the repeated abscissa
        write_point(3, 32'sd5, 32'sd1);
        query(32'sd10);
        // unordered table
        write_point(1, 32'sd100 <<< 16, -32'sd9 <<< 16);
        write_point(2, -32'sd50 <<< 16, 32'sd4 <<< 16);
        write_point(3, 32'sd20 <<< 16, 32'sd2 <<< 16);
        query(-32'sd60 <<< 16);
        query(32'sd10 <<< 16);

        run_phase(4'd0, 0, 0, 150, 0);
        run_phase(4'd2, 78, 0, 150, 0);
        run_phase(4'd3, 0, 78, 150, 0);
        run_phase(4'd15, 37, 37, 40, 0);
        run_phase(4'd1, 37, 37, 150, 0);
        run_phase(4'd5, 0, 0, 100, 0);
        run_phase(4'd2, 0, 0, 100, 4000);
        run_phase(4'd8, 0, 0, 20, 0);
        run_phase(4'd2, 78, 78, 150, 0);

        i_in_valid = 1'b0;
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
